[rtl/core/tlg_pkg.sv]
// ----------------------------------------------------------------------------
// tlg_pkg: shared types and codes for the toroidal life grid
// Request and result payloads, action codes and register indexes.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    localparam int CfgW = 7;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] row_index;
        logic [5:0] col_index;
        logic       alive_in;
    } t_req;

    typedef struct packed {
        logic alive_out;
        logic done_res;
    } t_res;

endpackage

[rtl/core/toroidal_life_grid_core.sv]
// ----------------------------------------------------------------------------
// toroidal_life_grid_core: Game of Life grid on a torus
// Writes, reads and advances a row-wide cell memory one request at a time.
// ----------------------------------------------------------------------------
// Channel   | Direction | Handshake                | Payload
// request   | in        | start & !busy            | i_req (action, row, col, alive_in)
// result    | out       | o_strobe, one cycle      | o_res (alive_out, done_res)
// config    | in        | i_cfg_we, no wait        | i_cfg_idx, i_cfg_data
//
// Cell write: row read, then modify and write back. Cell read: row read, then bit out.
// Advance: rows stream through the memory read port into a five-row window,
// one row read per cycle.
// After reset a clearing pass zeroes MAX_ROWS rows, one per cycle; busy holds.
// A result shows for one cycle, in the same cycle that busy drops; the receiver
// cannot stall, so the next request may be accepted meanwhile.
// ----------------------------------------------------------------------------
module toroidal_life_grid_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tlg_pkg::t_req          i_req,
    output logic                   o_strobe,
    output tlg_pkg::t_res          o_res,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [tlg_pkg::CfgW-1:0] i_cfg_data
);
    import tlg_pkg::*;

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RSW = $clog2(MAX_ROWS + 1);
    localparam int CSW = $clog2(MAX_COLS + 1);
    localparam int KW  = $clog2(MAX_ROWS + 4);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CELL, ST_ADV} t_state;

    t_state r_state;
    logic [CfgW-1:0] r_cfg_rows, r_cfg_cols;
    logic            r_cfg_mode;
    logic [RAW-1:0]  r_clr;
    logic [1:0]      r_act;
    logic [RAW-1:0]  r_row_addr;
    logic [CAW-1:0]  r_col_addr;
    logic            r_alive, r_inside;
    logic            r_iss_on, r_a_vld, r_a_mem, r_w_vld;
    logic [KW-1:0]   r_k, r_a_k, r_w_k;
    logic [MAX_COLS-1:0] r_save0, r_save1;
    logic [MAX_COLS-1:0] r_win [5];
    logic            r_strobe;
    t_res            r_res;

    // clamp sizes to 4..MAX
    logic [RSW+6:0] rows_w;
    logic [CSW+6:0] cols_w;
    logic [RSW-1:0] rows_use;
    logic [CSW-1:0] cols_use;

    assign rows_w = (RSW+7)'(r_cfg_rows);
    assign cols_w = (CSW+7)'(r_cfg_cols);

    always_comb begin
        logic [RSW+6:0] rv;
        logic [CSW+6:0] cv;
        if (rows_w < (RSW+7)'(4)) rv = (RSW+7)'(4);
        else if (rows_w > (RSW+7)'(MAX_ROWS)) rv = (RSW+7)'(MAX_ROWS);
        else rv = rows_w;
        if (cols_w < (CSW+7)'(4)) cv = (CSW+7)'(4);
        else if (cols_w > (CSW+7)'(MAX_COLS)) cv = (CSW+7)'(MAX_COLS);
        else cv = cols_w;
        rows_use = rv[RSW-1:0];
        cols_use = cv[CSW-1:0];
    end

    logic accept, in_grid;
    logic [RAW+5:0] row_w;
    logic [CAW+5:0] col_w;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign row_w   = (RAW+6)'(i_req.row_index);
    assign col_w   = (CAW+6)'(i_req.col_index);
    assign in_grid = ((RSW+6)'(i_req.row_index) < (RSW+6)'(rows_use))
                  && ((CSW+6)'(i_req.col_index) < (CSW+6)'(cols_use));

    // advance sequencing: read k fetches row k-2 (wrapped); the last two
    // reads come from saved copies of rows 0 and 1, already overwritten
    logic [KW-1:0] nrk, rd_k_addr, wr_k_row;
    logic          issue, adv_wr, adv_last;

    assign nrk       = KW'(rows_use);
    assign issue     = (r_state == ST_ADV) && r_iss_on;
    assign rd_k_addr = (r_k < KW'(2)) ? (nrk - KW'(2) + r_k) : (r_k - KW'(2));
    assign wr_k_row  = r_w_k - KW'(4);
    assign adv_wr    = (r_state == ST_ADV) && r_w_vld && (r_w_k >= KW'(4));
    assign adv_last  = adv_wr && (r_w_k == nrk + KW'(3));

    logic                 mem_rd_en, mem_wr_en;
    logic [RAW-1:0]       mem_rd_addr, mem_wr_addr;
    logic [MAX_COLS-1:0]  mem_rd_data, mem_wr_data, row_mod, new_row, win_in;

    always_comb begin
        row_mod = mem_rd_data;
        row_mod[r_col_addr] = r_alive;
    end

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = row_w[RAW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_row_addr;
        mem_wr_data = row_mod;
        unique case (r_state)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
                mem_wr_data = '0;
            end
            ST_IDLE: begin
                mem_rd_en = accept && in_grid
                         && (i_req.action == ACT_WRITE || i_req.action == ACT_READ);
            end
            ST_CELL: begin
                mem_wr_en = (r_act == ACT_WRITE) && r_inside;
            end
            ST_ADV: begin
                mem_rd_en   = issue && (r_k < nrk + KW'(2));
                mem_rd_addr = rd_k_addr[RAW-1:0];
                mem_wr_en   = adv_wr;
                mem_wr_addr = wr_k_row[RAW-1:0];
                mem_wr_data = new_row;
            end
            default: ;
        endcase
    end

    assign win_in = r_a_mem ? mem_rd_data
                  : ((r_a_k == nrk + KW'(2)) ? r_save0 : r_save1);

    tlg_row_mem #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    tlg_row_rule #(.MAX_COLS(MAX_COLS)) u_rule (
        .i_row_m2 (r_win[0]),
        .i_row_m1 (r_win[1]),
        .i_row_c  (r_win[2]),
        .i_row_p1 (r_win[3]),
        .i_row_p2 (r_win[4]),
        .i_cols   (cols_use),
        .i_mode   (r_cfg_mode),
        .o_row    (new_row)
    );

    // window and saved rows: payload only
    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= r_win[4];
            r_win[4] <= win_in;
            if (r_a_k == KW'(2)) r_save0 <= win_in;
            if (r_a_k == KW'(3)) r_save1 <= win_in;
        end
        r_a_k <= r_k;
        r_a_mem <= r_k < nrk + KW'(2);
        r_w_k <= r_a_k;
        if (accept) begin
            r_row_addr <= row_w[RAW-1:0];
            r_col_addr <= col_w[CAW-1:0];
            r_alive    <= i_req.alive_in;
            r_inside   <= in_grid;
            r_act      <= i_req.action;
        end
    end

    // control, config and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cfg_rows <= CfgW'(64);
            r_cfg_cols <= CfgW'(64);
            r_cfg_mode <= 1'b0;
            r_clr      <= '0;
            r_k        <= '0;
            r_iss_on   <= 1'b0;
            r_a_vld    <= 1'b0;
            r_w_vld    <= 1'b0;
            r_strobe   <= 1'b0;
            r_res      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ROWS: r_cfg_rows <= i_cfg_data;
                    REG_COLS: r_cfg_cols <= i_cfg_data;
                    REG_MODE: r_cfg_mode <= i_cfg_data[0];
                    default:  ;
                endcase
            end
            r_strobe <= 1'b0;
            r_a_vld  <= issue;
            r_w_vld  <= r_a_vld;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + RAW'(1);
                    if (r_clr == RAW'(MAX_ROWS - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        if (i_req.action == ACT_ADVANCE) begin
                            r_state  <= ST_ADV;
                            r_k      <= '0;
                            r_iss_on <= 1'b1;
                        end else begin
                            r_state <= ST_CELL;
                        end
                    end
                end
                ST_CELL: begin
                    // hand back the read bit; action 3 reports not done
                    r_state         <= ST_IDLE;
                    r_strobe        <= 1'b1;
                    r_res.alive_out <= (r_act == ACT_READ) && r_inside
                                    && mem_rd_data[r_col_addr];
                    r_res.done_res  <= (r_act == ACT_WRITE) || (r_act == ACT_READ);
                end
                ST_ADV: begin
                    if (issue) begin
                        r_k <= r_k + KW'(1);
                        if (r_k == nrk + KW'(3)) r_iss_on <= 1'b0;
                    end
                    if (adv_last) begin
                        r_state         <= ST_IDLE;
                        r_strobe        <= 1'b1;
                        r_res.alive_out <= 1'b0;
                        r_res.done_res  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // a cell request always reports on the following cycle
    a_cell_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL) |=> o_strobe)
        else $error("cell request gave no result");

    // never read and write the same row in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("row read and write collide");

    // advance writes stay inside the rows in use
    a_adv_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_wr |-> (wr_k_row < nrk))
        else $error("advance wrote beyond rows in use");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

endmodule

[rtl/core/tlg_row_mem.sv]
// ----------------------------------------------------------------------------
// tlg_row_mem: row-wide grid memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlg_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/core/tlg_row_rule.sv]
// ----------------------------------------------------------------------------
// tlg_row_rule: next generation of one row
// Counts neighbours per column from a five-row window and applies the rule.
// ----------------------------------------------------------------------------
module tlg_row_rule #(
    parameter int MAX_COLS = 64
) (
    input  logic [MAX_COLS-1:0]         i_row_m2,
    input  logic [MAX_COLS-1:0]         i_row_m1,
    input  logic [MAX_COLS-1:0]         i_row_c,
    input  logic [MAX_COLS-1:0]         i_row_p1,
    input  logic [MAX_COLS-1:0]         i_row_p2,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_cols,
    input  logic                        i_mode,
    output logic [MAX_COLS-1:0]         o_row
);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int CSW = $clog2(MAX_COLS+1);

    logic [CSW-1:0] last1_w, last2_w;
    logic [CAW-1:0] last1, last2;

    assign last1_w = i_cols - CSW'(1);
    assign last2_w = i_cols - CSW'(2);
    assign last1   = last1_w[CAW-1:0];
    assign last2   = last2_w[CAW-1:0];

    // wrap one column left
    function automatic logic [MAX_COLS-1:0] f_left1(input logic [MAX_COLS-1:0] x,
                                                    input logic [CAW-1:0] l1);
        logic [MAX_COLS-1:0] y;
        y = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            y[c] = (c == 0) ? x[l1] : x[(c == 0) ? 0 : c - 1];
        end
        return y;
    endfunction

    function automatic logic [MAX_COLS-1:0] f_left2(input logic [MAX_COLS-1:0] x,
                                                    input logic [CAW-1:0] l1,
                                                    input logic [CAW-1:0] l2);
        logic [MAX_COLS-1:0] y;
        y = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            if (c == 0) y[c] = x[l2];
            else if (c == 1) y[c] = x[l1];
            else y[c] = x[(c < 2) ? 0 : c - 2];
        end
        return y;
    endfunction

    function automatic logic [MAX_COLS-1:0] f_right1(input logic [MAX_COLS-1:0] x,
                                                     input logic [CAW-1:0] l1);
        logic [MAX_COLS-1:0] y;
        y = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            if (CAW'(c) == l1) y[c] = x[0];
            else y[c] = (c + 1 < MAX_COLS) ? x[(c + 1 < MAX_COLS) ? c + 1 : 0] : 1'b0;
        end
        return y;
    endfunction

    function automatic logic [MAX_COLS-1:0] f_right2(input logic [MAX_COLS-1:0] x,
                                                     input logic [CAW-1:0] l1,
                                                     input logic [CAW-1:0] l2);
        logic [MAX_COLS-1:0] y;
        y = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            if (CAW'(c) == l2) y[c] = x[0];
            else if (CAW'(c) == l1) y[c] = x[1];
            else y[c] = (c + 2 < MAX_COLS) ? x[(c + 2 < MAX_COLS) ? c + 2 : 0] : 1'b0;
        end
        return y;
    endfunction

    logic [MAX_COLS-1:0] m1_l, m1_r, p1_l, p1_r, c_l1, c_r1, c_l2, c_r2;

    assign m1_l = f_left1(i_row_m1, last1);
    assign m1_r = f_right1(i_row_m1, last1);
    assign p1_l = f_left1(i_row_p1, last1);
    assign p1_r = f_right1(i_row_p1, last1);
    assign c_l1 = f_left1(i_row_c, last1);
    assign c_r1 = f_right1(i_row_c, last1);
    assign c_l2 = f_left2(i_row_c, last1, last2);
    assign c_r2 = f_right2(i_row_c, last1, last2);

    always_comb begin
        logic [3:0] cnt;
        o_row = i_row_c;
        for (int c = 0; c < MAX_COLS; c++) begin
            if (i_mode) begin
                cnt = 4'(i_row_m2[c]) + 4'(i_row_m1[c]) + 4'(i_row_p1[c]) + 4'(i_row_p2[c])
                    + 4'(c_l2[c]) + 4'(c_l1[c]) + 4'(c_r1[c]) + 4'(c_r2[c]);
            end else begin
                cnt = 4'(m1_l[c]) + 4'(i_row_m1[c]) + 4'(m1_r[c]) + 4'(c_l1[c])
                    + 4'(c_r1[c]) + 4'(p1_l[c]) + 4'(i_row_p1[c]) + 4'(p1_r[c]);
            end
            if (CSW'(c) < i_cols) begin
                o_row[c] = (cnt == 4'd3) || (i_row_c[c] && (cnt == 4'd2));
            end
        end
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for toroidal_life_grid_core
// Runs directed and random write, advance and read requests over several grid
// sizes and both neighbour modes. A cycle-free predictor of the life grid
// forms the expected results, which the monitor compares field by field.
// ----------------------------------------------------------------------------
module testbench;
    import tlg_pkg::*;

    localparam int GRID_MAX  = 64;
    localparam int IDLE_MAX  = 17;
    localparam int DOG_LIMIT = 3000;
    localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code
    localparam logic [1:0] REG_NONE = 2'd3;  // unused register index

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             o_strobe;
    t_res             o_res;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CfgW-1:0]  i_cfg_data;

    toroidal_life_grid_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted grid state and register shadows
    bit         life_cells [GRID_MAX][GRID_MAX];
    logic [6:0] rows_raw;
    logic [6:0] cols_raw;
    logic       mode_cross;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   sent_cnt;
    int   taken_cnt;
    int   idle_left;
    bit   idle_en;
    bit   failed;
    int   quiet_cycles;

    // Clamp a raw size register to the range the grid honors
    function automatic int used_size(logic [6:0] raw);
        if (raw < 4) return 4;
        if (raw > GRID_MAX) return GRID_MAX;
        return int'(raw);
    endfunction

    // Compute one generation over the used area; cells beyond it are left alone
    task automatic advance_life();
        int dr_moore [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
        int dc_moore [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
        int dr_cross [8] = '{-2, -1, 1, 2, 0, 0, 0, 0};
        int dc_cross [8] = '{0, 0, 0, 0, -2, -1, 1, 2};
        bit nxt [GRID_MAX][GRID_MAX];
        int nr;
        int nc;
        int cnt;
        int rr;
        int cc;
        nr  = used_size(rows_raw);
        nc  = used_size(cols_raw);
        nxt = life_cells;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                cnt = 0;
                for (int k = 0; k < 8; k++) begin
                    rr  = (r + 2 * nr + (mode_cross ? dr_cross[k] : dr_moore[k])) % nr;
                    cc  = (c + 2 * nc + (mode_cross ? dc_cross[k] : dc_moore[k])) % nc;
                    cnt += life_cells[rr][cc];
                end
                if (life_cells[r][c]) nxt[r][c] = (cnt == 2 || cnt == 3);
                else nxt[r][c] = (cnt == 3);
            end
        end
        life_cells = nxt;
    endtask

    // Apply one accepted request to the predicted grid and return its result
    task automatic predict_request(input t_req rq, output t_res rs);
        bit in_grid;
        in_grid = (rq.row_index < used_size(rows_raw))
               && (rq.col_index < used_size(cols_raw));
        rs = '{alive_out: 1'b0, done_res: 1'b1};
        case (rq.action)
            ACT_WRITE: begin
                if (in_grid) life_cells[rq.row_index][rq.col_index] = rq.alive_in;
            end
            ACT_ADVANCE: begin
                advance_life();
            end
            ACT_READ: begin
                if (in_grid) rs.alive_out = life_cells[rq.row_index][rq.col_index];
            end
            default: begin
                rs.done_res = 1'b0;
            end
        endcase
    endtask

    task automatic push_req(logic [1:0] act, int r, int c, int a);
        t_req rq;
        rq.action    = act;
        rq.row_index = r[5:0];
        rq.col_index = c[5:0];
        rq.alive_in  = a[0];
        pending_reqs.push_back(rq);
    endtask

    // Wait until every request is taken and every result is back
    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || busy || expected_res.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CfgW-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Fill the request queue for one phase: mostly seeded patterns that are
    // advanced and read back, the rest scattered noise of every action
    task automatic fill_random(int count);
        int nr;
        int nc;
        int k;
        nr = used_size(rows_raw);
        nc = used_size(cols_raw);
        while (count > 0) begin
            if ($urandom_range(0, 9) < 6) begin
                k = $urandom_range(3, 8);
                for (int i = 0; i < k; i++)
                    push_req(ACT_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                             $urandom_range(0, 3) != 0);
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) push_req(ACT_ADVANCE, $urandom, $urandom, $urandom);
                k = $urandom_range(2, 6);
                for (int i = 0; i < k; i++)
                    push_req(ACT_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                             $urandom);
                count -= 14;
            end else begin
                k = $urandom_range(0, 19);
                if (k < 6)       push_req(ACT_WRITE, $urandom, $urandom, $urandom);
                else if (k < 14) push_req(ACT_READ, $urandom, $urandom, $urandom);
                else if (k < 17) push_req(ACT_ADVANCE, $urandom, $urandom, $urandom);
                else             push_req(ACT_NONE, $urandom, $urandom, $urandom);
                count--;
            end
        end
    endtask

    task automatic run_phase(int rows, int cols, int mode, int count, bit idle);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_MODE, mode);
        @(posedge i_clk);
        idle_en = idle;
        fill_random(count);
        drain();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: present the next request at the falling edge, hold it until
    // taken, and drop random idle bursts in between
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && taken_cnt != sent_cnt) begin
            // hold the request until busy lets it through
        end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
        end else if (pending_reqs.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
            idle_left <= $urandom_range(0, IDLE_MAX - 1);
            start     <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            i_req    <= pending_reqs.pop_front();
            start    <= 1'b1;
            sent_cnt <= sent_cnt + 1;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: predict on every taken request, check every strobed result,
    // track register writes and watch for a stalled block
    always @(posedge i_clk) begin
        t_res rs;
        t_res want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: rows_raw   = i_cfg_data;
                    REG_COLS: cols_raw   = i_cfg_data;
                    REG_MODE: mode_cross = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_strobe) begin
                if (expected_res.size() == 0) begin
                    $error("result with none expected: alive_out %0d done_res %0d",
                           o_res.alive_out, o_res.done_res);
                    failed = 1'b1;
                end else begin
                    want = expected_res.pop_front();
                    if (o_res.alive_out !== want.alive_out) begin
                        $error("alive_out: expected %0d, actual %0d", want.alive_out,
                               o_res.alive_out);
                        failed = 1'b1;
                    end
                    if (o_res.done_res !== want.done_res) begin
                        $error("done_res: expected %0d, actual %0d", want.done_res,
                               o_res.done_res);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy) begin
                predict_request(i_req, rs);
                expected_res.push_back(rs);
                taken_cnt = taken_cnt + 1;
            end
            if ((start && !busy) || o_strobe) quiet_cycles = 0;
            else quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= DOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        rows_raw   = 7'd64;
        cols_raw   = 7'd64;
        mode_cross = 1'b0;
        sent_cnt   = 0;
        taken_cnt  = 0;
        idle_left  = 0;
        idle_en    = 1'b1;
        failed     = 1'b0;
        quiet_cycles = 0;
        foreach (life_cells[r, c]) life_cells[r][c] = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // let the clearing pass finish
        do @(posedge i_clk); while (busy);

        // Directed: corners of the full grid, the unused action, both values
        push_req(ACT_READ, 63, 63, 0);
        push_req(ACT_WRITE, 0, 0, 1);
        push_req(ACT_WRITE, 63, 63, 1);
        push_req(ACT_WRITE, 0, 63, 1);
        push_req(ACT_READ, 0, 0, 1);
        push_req(ACT_READ, 63, 63, 0);
        push_req(ACT_NONE, 63, 63, 1);
        push_req(ACT_ADVANCE, 0, 0, 0);
        push_req(ACT_READ, 63, 0, 0);
        push_req(ACT_WRITE, 0, 0, 0);
        push_req(ACT_READ, 0, 0, 0);
        drain();

        // Directed: smallest torus in cross mode, where offsets fold onto the
        // same cell, plus writes and reads outside the used area
        write_reg(REG_ROWS, 4);
        write_reg(REG_COLS, 4);
        write_reg(REG_MODE, 1);
        push_req(ACT_WRITE, 0, 1, 1);
        push_req(ACT_WRITE, 0, 3, 1);
        push_req(ACT_WRITE, 2, 0, 1);
        push_req(ACT_WRITE, 5, 5, 1);
        push_req(ACT_READ, 5, 5, 0);
        push_req(ACT_ADVANCE, 0, 0, 0);
        push_req(ACT_READ, 0, 0, 0);
        push_req(ACT_READ, 2, 0, 0);
        push_req(ACT_READ, 3, 3, 0);
        push_req(ACT_ADVANCE, 0, 0, 0);
        push_req(ACT_READ, 0, 1, 0);
        drain();

        // Random phases across sizes, clamped values and both modes; the
        // unused register index is written once too
        write_reg(REG_NONE, 127);
        run_phase(4, 4, 0, 60, 1'b1);
        run_phase(0, 3, 1, 50, 1'b1);
        run_phase(8, 6, 0, 70, 1'b1);
        run_phase(127, 100, 1, 50, 1'b1);
        run_phase(5, 7, 1, 70, 1'b1);
        run_phase(16, 10, 0, 70, 1'b1);
        run_phase(64, 65, 0, 40, 1'b1);
        run_phase(6, 9, 1, 70, 1'b0);

        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
